@@ sv/selective_repeat_sender_window_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_ASSERT_SVH

// plain property, checked every cycle out of reset
`define SRSW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication
`define SRSW_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ sv/srsw_pkg.sv @@
// ----------------------------------------------------------------------------
// srsw_pkg
// Types and constants shared by the selective-repeat sender window modules.
// ----------------------------------------------------------------------------
package srsw_pkg;

   localparam int unsigned CSR_ADDR_BITS = 4;

   localparam logic [4:0]  WINDOW_SIZE_RESET = 5'd5;
   localparam logic [31:0] TOTAL_RESET       = 32'd0;
   localparam logic [15:0] TIMEOUT_RESET     = 16'd500;
   localparam logic [31:0] MAX_TOTAL         = 32'hFFFF_FFFE;

   typedef enum logic [1:0] {
      REG_WINDOW_SIZE = 2'd0,
      REG_TOTAL       = 2'd1,
      REG_TIMEOUT     = 2'd2
   } reg_index_type;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_ACK  = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic accept_tick;
      logic accept_ack;
      logic prep;
      logic scan_rd;
      logic scan_cmp;
      logic retx_init;
      logic send_new;
      logic send_retx;
      logic ack_mark;
      logic ack_slide;
      logic quiet;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
      logic new_pending;
      logic new_last;
      logic retx_pending;
      logic retx_last;
      logic slide_more;
   } status_type;

endpackage

@@ sv/srsw_csr.sv @@
// ----------------------------------------------------------------------------
// srsw_csr
// APB register file: window size, total packet count, ack timeout.
// ----------------------------------------------------------------------------
module srsw_csr
   import srsw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready,
   output logic [4:0]               window_limit,
   output logic [31:0]              packet_count,
   output logic [15:0]              ack_timeout
);

   logic [4:0]    window_ff;
   logic [31:0]   total_ff;
   logic [15:0]   timeout_ff;
   logic          wr_en;
   reg_index_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;
   assign idx    = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_SIZE_RESET;
         total_ff   <= TOTAL_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (wr_en) begin
         unique case (idx)
            REG_WINDOW_SIZE: window_ff  <= pwdata[4:0];
            REG_TOTAL:       total_ff   <= pwdata;
            REG_TIMEOUT:     timeout_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_WINDOW_SIZE: prdata = {27'd0, window_ff};
         REG_TOTAL:       prdata = total_ff;
         REG_TIMEOUT:     prdata = {16'd0, timeout_ff};
         default:         prdata = 32'd0;
      endcase
   end

   assign window_limit = window_ff;
   assign packet_count = total_ff;
   assign ack_timeout  = timeout_ff;

endmodule

@@ sv/srsw_ctrl.sv @@
// ----------------------------------------------------------------------------
// srsw_ctrl
// Sequencer: tick prep, timeout scan, send emission, ack mark and base slide.
// ----------------------------------------------------------------------------
module srsw_ctrl
   import srsw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_operation,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SEND_NEW,
      S_SEND_RETX,
      S_ACK_MARK,
      S_ACK_SLIDE,
      S_QUIET
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_operation == OP_ACK) begin
                  cmd.accept_ack = 1'b1;
                  state_in       = S_ACK_MARK;
               end else begin
                  cmd.accept_tick = 1'b1;
                  state_in        = S_PREP;
               end
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            if (status.scan_done) begin
               cmd.retx_init = 1'b1;
               priority if (status.new_pending) state_in = S_SEND_NEW;
               else if (status.retx_pending)    state_in = S_SEND_RETX;
               else                             state_in = S_QUIET;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in     = S_SCAN_RD;
         end
         S_SEND_NEW: begin
            cmd.send_new = 1'b1;
            if (status.new_last) begin
               state_in = status.retx_pending ? S_SEND_RETX : S_IDLE;
            end
         end
         S_SEND_RETX: begin
            cmd.send_retx = 1'b1;
            if (status.retx_last) begin
               state_in = S_IDLE;
            end
         end
         S_ACK_MARK: begin
            cmd.ack_mark = 1'b1;
            state_in     = S_ACK_SLIDE;
         end
         S_ACK_SLIDE: begin
            if (status.slide_more) begin
               cmd.ack_slide = 1'b1;
            end else begin
               state_in = S_QUIET;
            end
         end
         S_QUIET: begin
            cmd.quiet = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

@@ sv/srsw_datapath.sv @@
// ----------------------------------------------------------------------------
// srsw_datapath
// Window pointers, slot flags, send-time memory, retransmit counter and
// the registered response outputs.
// ----------------------------------------------------------------------------
module srsw_datapath
   import srsw_pkg::*;
#(
   parameter int unsigned WINDOW_SLOTS = 16,
   parameter int unsigned TIME_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [31:0] req_ack_number,
   input  logic [4:0]  window_limit,
   input  logic [31:0] packet_count,
   input  logic [15:0] ack_timeout,
   output logic        rsp_strobe,
   output logic        rsp_send_valid,
   output logic [31:0] rsp_send_seq,
   output logic        rsp_is_retransmit,
   output logic        rsp_last,
   output logic [31:0] rsp_window_base,
   output logic [31:0] rsp_next_sequence,
   output logic        rsp_transfer_done,
   output logic [31:0] rsp_retransmissions
);

   `include "selective_repeat_sender_window_assert.svh"

   localparam int unsigned SW  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int unsigned CW  = $clog2(WINDOW_SLOTS + 1);
   localparam int unsigned AW  = (TIME_BITS > 16) ? TIME_BITS : 16;
   localparam logic [SW-1:0] SLOT_LAST  = SW'(WINDOW_SLOTS - 1);
   localparam logic [SW-1:0] SLOT_RESET = SW'(1 % WINDOW_SLOTS);
   localparam logic [SW:0]   SLOTS_WIDE = (SW + 1)'(WINDOW_SLOTS);

   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
      return (s == SLOT_LAST) ? '0 : s + 1'b1;
   endfunction

   // window pointers
   logic [31:0]          base_ff, next_ff, end_ff, cur_ff, ack_ff;
   logic [SW-1:0]        base_slot_ff, next_slot_ff, cur_slot_ff;
   logic [32:0]          limit_ff;
   logic [TIME_BITS-1:0] tick_ff, rd_time_ff;
   logic [31:0]          retx_total_ff;
   logic [CW-1:0]        retx_left_ff;
   logic                 acked_ff [WINDOW_SLOTS];
   logic                 mask_ff  [WINDOW_SLOTS];
   logic [TIME_BITS-1:0] sent_mem [WINDOW_SLOTS];

   // outputs
   logic        strobe_ff, send_valid_ff, is_retx_ff, last_ff, done_ff;
   logic [31:0] send_seq_ff;

   logic [31:0]          eff_total, win_in, end_in, ack_off;
   logic [32:0]          total_p1, cap_in;
   logic [TIME_BITS-1:0] age;
   logic                 timed_out, scan_hit, ack_in_win;
   logic [SW:0]          ack_sum;
   logic [SW-1:0]        ack_slot;
   logic                 mem_we;
   logic [SW-1:0]        mem_waddr;

   assign eff_total = (packet_count > MAX_TOTAL) ? MAX_TOTAL : packet_count;
   assign win_in    = (32'(window_limit) > 32'(WINDOW_SLOTS)) ? 32'(WINDOW_SLOTS)
                                                              : 32'(window_limit);
   assign total_p1  = {1'b0, eff_total} + 33'd1;
   assign cap_in    = (limit_ff < total_p1) ? limit_ff : total_p1;
   assign end_in    = (cap_in > {1'b0, next_ff}) ? cap_in[31:0] : next_ff;

   assign age       = tick_ff - rd_time_ff;
   assign timed_out = AW'(age) >= AW'(ack_timeout);
   assign scan_hit  = !acked_ff[cur_slot_ff] && timed_out;

   // offset from base is below the slot count whenever the ack is in window
   assign ack_in_win = (ack_ff >= base_ff) && (ack_ff < next_ff);
   assign ack_off    = ack_ff - base_ff;
   assign ack_sum    = {1'b0, base_slot_ff} + ack_off[SW:0];
   assign ack_slot   = (ack_sum >= SLOTS_WIDE) ? SW'(ack_sum - SLOTS_WIDE)
                                               : ack_sum[SW-1:0];

   assign mem_we    = cmd.send_new || (cmd.scan_cmp && scan_hit);
   assign mem_waddr = cmd.send_new ? next_slot_ff : cur_slot_ff;

   always_comb begin
      status.scan_done    = (cur_ff == next_ff);
      status.new_pending  = (next_ff != end_ff);
      status.new_last     = ((next_ff + 32'd1) == end_ff);
      status.retx_pending = (retx_left_ff != '0);
      status.retx_last    = mask_ff[cur_slot_ff] && (retx_left_ff == CW'(1));
      status.slide_more   = (base_ff != next_ff) && acked_ff[base_slot_ff];
   end

   // send-time store: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sent_mem[mem_waddr] <= tick_ff;
      end
      if (cmd.scan_rd) begin
         rd_time_ff <= sent_mem[cur_slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= 32'd1;
         next_ff       <= 32'd1;
         end_ff        <= 32'd1;
         cur_ff        <= 32'd1;
         base_slot_ff  <= SLOT_RESET;
         next_slot_ff  <= SLOT_RESET;
         cur_slot_ff   <= SLOT_RESET;
         tick_ff       <= '0;
         retx_total_ff <= '0;
         retx_left_ff  <= '0;
         strobe_ff     <= 1'b0;
         for (int i = 0; i < WINDOW_SLOTS; i++) begin
            acked_ff[i] <= 1'b0;
            mask_ff[i]  <= 1'b0;
         end
      end else begin
         strobe_ff <= cmd.send_new || (cmd.send_retx && mask_ff[cur_slot_ff]) || cmd.quiet;

         if (cmd.accept_tick) begin
            tick_ff      <= tick_ff + 1'b1;
            cur_ff       <= base_ff;
            cur_slot_ff  <= base_slot_ff;
            retx_left_ff <= '0;
            for (int i = 0; i < WINDOW_SLOTS; i++) begin
               mask_ff[i] <= 1'b0;
            end
         end
         if (cmd.accept_ack) begin
            end_ff <= next_ff;
         end
         if (cmd.prep) begin
            end_ff <= end_in;
         end

         if (cmd.scan_cmp) begin
            if (scan_hit) begin
               mask_ff[cur_slot_ff] <= 1'b1;
               retx_left_ff         <= retx_left_ff + 1'b1;
               if (retx_total_ff != '1) begin
                  retx_total_ff <= retx_total_ff + 32'd1;
               end
            end
            cur_ff      <= cur_ff + 32'd1;
            cur_slot_ff <= slot_inc(cur_slot_ff);
         end

         if (cmd.retx_init) begin
            cur_ff      <= base_ff;
            cur_slot_ff <= base_slot_ff;
         end

         if (cmd.send_new) begin
            acked_ff[next_slot_ff] <= 1'b0;
            next_ff                <= next_ff + 32'd1;
            next_slot_ff           <= slot_inc(next_slot_ff);
         end

         if (cmd.send_retx) begin
            if (mask_ff[cur_slot_ff]) begin
               mask_ff[cur_slot_ff] <= 1'b0;
               retx_left_ff         <= retx_left_ff - 1'b1;
            end
            cur_ff      <= cur_ff + 32'd1;
            cur_slot_ff <= slot_inc(cur_slot_ff);
         end

         if (cmd.ack_mark && ack_in_win) begin
            acked_ff[ack_slot] <= 1'b1;
         end

         if (cmd.ack_slide) begin
            acked_ff[base_slot_ff] <= 1'b0;
            base_ff                <= base_ff + 32'd1;
            base_slot_ff           <= slot_inc(base_slot_ff);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept_tick) begin
         limit_ff <= {1'b0, base_ff} + {1'b0, win_in};
      end
      if (cmd.accept_ack) begin
         ack_ff <= req_ack_number;
      end
      if (cmd.send_new) begin
         send_valid_ff <= 1'b1;
         send_seq_ff   <= next_ff;
         is_retx_ff    <= 1'b0;
         last_ff       <= status.new_last && (retx_left_ff == '0);
         done_ff       <= base_ff > eff_total;
      end else if (cmd.send_retx) begin
         send_valid_ff <= 1'b1;
         send_seq_ff   <= cur_ff;
         is_retx_ff    <= 1'b1;
         last_ff       <= (retx_left_ff == CW'(1));
         done_ff       <= base_ff > eff_total;
      end else if (cmd.quiet) begin
         send_valid_ff <= 1'b0;
         send_seq_ff   <= 32'd0;
         is_retx_ff    <= 1'b0;
         last_ff       <= 1'b1;
         done_ff       <= base_ff > eff_total;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_send_valid      = send_valid_ff;
   assign rsp_send_seq        = send_seq_ff;
   assign rsp_is_retransmit   = is_retx_ff;
   assign rsp_last            = last_ff;
   assign rsp_window_base     = base_ff;
   assign rsp_next_sequence   = end_ff;
   assign rsp_transfer_done   = done_ff;
   assign rsp_retransmissions = retx_total_ff;

   `SRSW_ASSERT(a_base_le_next, base_ff <= next_ff, "base passed next sequence")
   `SRSW_ASSERT(a_window_fits, (next_ff - base_ff) <= 32'(WINDOW_SLOTS),
                "outstanding packets exceed slot count")
   `SRSW_ASSERT_IMPL(a_retx_count, cmd.send_retx, retx_left_ff != '0,
                     "retransmit emission with no pending retransmits")

endmodule

@@ sv/selective_repeat_sender_window.sv @@
// Tick: prep, a timeout scan of each outstanding old slot, then one emission per new
//   send and per old slot up to the last retransmit; ack: mark, then slide the base.
// One request at a time, busy while the sequencer runs; the timeout scan
//   over the send-time memory (read then compare per slot) sets the tick length.
// Results appear in the cycle after they are formed and cannot be stalled.
// Synchronous active-high reset: base and next sequence 1, counters zero, slot flags clear.
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender side of a selective-repeat ARQ window with APB configuration.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window
   import srsw_pkg::*;
#(
   parameter int unsigned WINDOW_SLOTS = 16,
   parameter int unsigned TIME_BITS    = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_operation,
   input  logic [31:0]              req_ack_number,
   output logic                     rsp_strobe,
   output logic                     rsp_send_valid,
   output logic [31:0]              rsp_send_seq,
   output logic                     rsp_is_retransmit,
   output logic                     rsp_last,
   output logic [31:0]              rsp_window_base,
   output logic [31:0]              rsp_next_sequence,
   output logic                     rsp_transfer_done,
   output logic [31:0]              rsp_retransmissions,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   cmd_type     cmd;
   status_type  status;
   logic [4:0]  window_limit;
   logic [31:0] packet_count;
   logic [15:0] ack_timeout;

   srsw_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .window_limit (window_limit),
      .packet_count (packet_count),
      .ack_timeout  (ack_timeout)
   );

   srsw_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   srsw_datapath #(
      .WINDOW_SLOTS (WINDOW_SLOTS),
      .TIME_BITS    (TIME_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_ack_number      (req_ack_number),
      .window_limit        (window_limit),
      .packet_count        (packet_count),
      .ack_timeout         (ack_timeout),
      .rsp_strobe          (rsp_strobe),
      .rsp_send_valid      (rsp_send_valid),
      .rsp_send_seq        (rsp_send_seq),
      .rsp_is_retransmit   (rsp_is_retransmit),
      .rsp_last            (rsp_last),
      .rsp_window_base     (rsp_window_base),
      .rsp_next_sequence   (rsp_next_sequence),
      .rsp_transfer_done   (rsp_transfer_done),
      .rsp_retransmissions (rsp_retransmissions)
   );

endmodule
